// ===== rtl/core/lsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared sizes, status codes, control types and helper functions of the
// LSB-first bit packer.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  localparam int unsigned StoreBytes   = 256;
  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned AddrW        = $clog2(StoreBytes);
  localparam int unsigned StoreBits    = StoreBytes * 8;
  localparam int unsigned PosW         = AddrW + 3;
  localparam int unsigned TotalW       = PosW + 1;
  localparam int unsigned CountW       = 6;
  localparam int unsigned SpanW        = MaxFieldBits + 8;
  localparam int unsigned SpanBytes    = SpanW / 8;
  localparam int unsigned ByteCntW     = $clog2(SpanBytes + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_FULL      = 2'd2,
    ST_PAST_END  = 2'd3
  } lsbp_status_e;

  typedef struct packed {
    logic load;
    logic shift;
  } lsbp_shift_ctrl_t;

  // Mask of the low cnt bits; a full-width count takes every bit.
  function automatic logic [MaxFieldBits-1:0] field_mask(input logic [CountW-1:0] cnt);
    logic [MaxFieldBits-1:0] m;
    if (32'(cnt) >= MaxFieldBits) begin
      m = '1;
    end else begin
      m = ~({MaxFieldBits{1'b1}} << cnt);
    end
    return m;
  endfunction

  function automatic logic count_valid(input logic [CountW-1:0] cnt);
    return (cnt != '0) && (32'(cnt) <= MaxFieldBits);
  endfunction

endpackage

// ===== rtl/core/lsbp_byte_mem.sv =====
// ----------------------------------------------------------------------------
// lsbp_byte_mem
// Byte-wide store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lsbp_byte_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [lsbp_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      re_i,
  input  logic [lsbp_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [lsbp_pkg::StoreBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lsbp_shift_unit.sv =====
// ----------------------------------------------------------------------------
// lsbp_shift_unit
// Byte-lane shift register shared by writes and reads. A write loads the
// aligned field and drains it a byte per beat; a read fills it a byte per
// beat from the top and then extracts the field at the bit offset.
// ----------------------------------------------------------------------------
module lsbp_shift_unit (
  input  logic                             clk_i,
  input  lsbp_pkg::lsbp_shift_ctrl_t       ctrl_i,
  input  logic [lsbp_pkg::SpanW-1:0]       load_data_i,
  input  logic [7:0]                       fill_byte_i,
  input  logic [2:0]                       offset_i,
  input  logic [lsbp_pkg::CountW-1:0]      count_i,
  output logic [7:0]                       low_byte_o,
  output logic [lsbp_pkg::MaxFieldBits-1:0] field_o
);

  logic [lsbp_pkg::SpanW-1:0] sh_q;
  logic [lsbp_pkg::SpanW-1:0] sh_d;
  logic [lsbp_pkg::SpanW-1:0] aligned;

  always_comb begin
    sh_d = sh_q;
    priority if (ctrl_i.load) begin
      sh_d = load_data_i;
    end else if (ctrl_i.shift) begin
      sh_d = {fill_byte_i, sh_q[lsbp_pkg::SpanW-1:8]};
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign aligned    = sh_q >> offset_i;
  assign low_byte_o = sh_q[7:0];
  assign field_o    = aligned[lsbp_pkg::MaxFieldBits-1:0] & lsbp_pkg::field_mask(count_i);

endmodule

// ===== rtl/core/lsb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Byte store filled as an LSB-first bitstream, with random-offset reads.
// ----------------------------------------------------------------------------
// Usage: present a request on req_type_i, data_value_i, bit_count_i and
// read_position_i with start high; it is taken on a clock edge where busy is
// low. busy stays high until the result beat has been shown. The result sits
// on read_data_o, status_o and written_bits_o for exactly one cycle with
// done_o high; the receiver cannot stall it and must take it then.
// Sequencing: a request with a bad bit count, a write that would overflow or a
// read past the written length goes straight to the result beat. A write of N
// bytes (1 to 5, set by the bit offset plus the bit count) stores its bytes in
// turn from the shift unit. A read always fetches 5 bytes through the single
// registered read port of the byte store, then aligns the field. One request is
// in flight at a time, so the next start is taken on the cycle after done_o.
// Reset clears the bit total and the sequencer; the store contents are not
// cleared, and no unwritten byte can ever be read back.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type_i,
  input  logic [31:0]                         data_value_i,
  input  logic [lsbp_pkg::CountW-1:0]         bit_count_i,
  input  logic [lsbp_pkg::PosW-1:0]           read_position_i,
  output logic                                done_o,
  output logic [lsbp_pkg::MaxFieldBits-1:0]   read_data_o,
  output logic [1:0]                          status_o,
  output logic [lsbp_pkg::TotalW-1:0]         written_bits_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic REQ_WRITE = 1'b0;

  logic [2:0]                         state_q, state_d;
  logic [lsbp_pkg::TotalW-1:0]        wtot_q, wtot_d;
  logic                               rd_vld_q, rd_vld_d;
  logic [7:0]                         tail_q, tail_d;
  logic [lsbp_pkg::AddrW-1:0]         addr_q, addr_d;
  logic [lsbp_pkg::ByteCntW-1:0]      cnt_q, cnt_d;
  logic [2:0]                         off_q, off_d;
  logic [lsbp_pkg::CountW-1:0]        count_q, count_d;
  logic [lsbp_pkg::MaxFieldBits-1:0]  res_data_q, res_data_d;
  lsbp_pkg::lsbp_status_e             res_status_q, res_status_d;

  lsbp_pkg::lsbp_shift_ctrl_t         sh_ctrl;
  logic [lsbp_pkg::SpanW-1:0]         sh_load;
  logic [7:0]                         sh_fill;
  logic [7:0]                         low_byte;
  logic [lsbp_pkg::MaxFieldBits-1:0]  field;

  logic                               mem_we;
  logic                               mem_re;
  logic [7:0]                         mem_rdata;

  logic [lsbp_pkg::MaxFieldBits-1:0]  wr_masked;
  logic [7:0]                         wr_tail;
  logic [lsbp_pkg::TotalW:0]          wr_end;
  logic [lsbp_pkg::TotalW-1:0]        rd_end;
  logic [6:0]                         wr_span;
  logic                               accept;

  assign accept = start && !busy;

  // Field masked and moved up to the write bit offset, merged with the
  // partial byte that the previous write left open.
  assign wr_masked = data_value_i & lsbp_pkg::field_mask(bit_count_i);
  assign wr_tail   = (wtot_q[2:0] != 3'd0) ? tail_q : 8'd0;
  assign sh_load   = ({8'd0, wr_masked} << wtot_q[2:0]) |
                     {{(lsbp_pkg::SpanW-8){1'b0}}, wr_tail};
  assign wr_end    = {1'b0, wtot_q} + (lsbp_pkg::TotalW+1)'(bit_count_i);
  assign rd_end    = {1'b0, read_position_i} + lsbp_pkg::TotalW'(bit_count_i);
  assign wr_span   = 7'(wtot_q[2:0]) + 7'(bit_count_i) + 7'd7;

  always_comb begin
    state_d      = state_q;
    wtot_d       = wtot_q;
    tail_d       = tail_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    off_d        = off_q;
    count_d      = count_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    sh_ctrl      = '0;
    sh_fill      = 8'd0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_data_d   = '0;
          res_status_d = lsbp_pkg::ST_OK;
          state_d      = S_DONE;
          if (!lsbp_pkg::count_valid(bit_count_i)) begin
            res_status_d = lsbp_pkg::ST_BAD_COUNT;
          end else if (req_type_i == REQ_WRITE) begin
            if (32'(wr_end) > lsbp_pkg::StoreBits) begin
              res_status_d = lsbp_pkg::ST_FULL;
            end else begin
              sh_ctrl.load = 1'b1;
              addr_d       = wtot_q[lsbp_pkg::PosW-1:3];
              cnt_d        = lsbp_pkg::ByteCntW'(wr_span >> 3);
              wtot_d       = wr_end[lsbp_pkg::TotalW-1:0];
              state_d      = S_WRITE;
            end
          end else begin
            if (rd_end > wtot_q) begin
              res_status_d = lsbp_pkg::ST_PAST_END;
            end else begin
              addr_d  = read_position_i[lsbp_pkg::PosW-1:3];
              cnt_d   = lsbp_pkg::ByteCntW'(lsbp_pkg::SpanBytes);
              off_d   = read_position_i[2:0];
              count_d = bit_count_i;
              state_d = S_READ;
            end
          end
        end
      end
      S_WRITE: begin
        mem_we        = 1'b1;
        sh_ctrl.shift = 1'b1;
        addr_d        = addr_q + 1'b1;
        cnt_d         = cnt_q - 1'b1;
        if (cnt_q == lsbp_pkg::ByteCntW'(1)) begin
          // The last byte stays open when the new total is not byte aligned.
          tail_d  = (wtot_q[2:0] != 3'd0) ? low_byte : 8'd0;
          state_d = S_DONE;
        end
      end
      S_READ: begin
        sh_fill = mem_rdata;
        if (cnt_q != '0) begin
          mem_re = 1'b1;
          addr_d = addr_q + 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end
        if (rd_vld_q) begin
          sh_ctrl.shift = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        res_data_d = field;
        state_d    = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_vld_d = mem_re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wtot_q   <= '0;
      rd_vld_q <= 1'b0;
      tail_q   <= 8'd0;
    end else begin
      state_q  <= state_d;
      wtot_q   <= wtot_d;
      rd_vld_q <= rd_vld_d;
      tail_q   <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    cnt_q        <= cnt_d;
    off_q        <= off_d;
    count_q      <= count_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
  end

  lsbp_shift_unit u_shift (
    .clk_i       (clk_i),
    .ctrl_i      (sh_ctrl),
    .load_data_i (sh_load),
    .fill_byte_i (sh_fill),
    .offset_i    (off_q),
    .count_i     (count_q),
    .low_byte_o  (low_byte),
    .field_o     (field)
  );

  lsbp_byte_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (low_byte),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign read_data_o    = res_data_q;
  assign status_o       = res_status_q;
  assign written_bits_o = wtot_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result beat");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != lsbp_pkg::ST_OK)) |-> (read_data_o == '0))
    else $error("nonzero read data on an error result");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(written_bits_o) <= lsbp_pkg::StoreBits)
    else $error("bit total exceeds store size");

  a_total_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> $stable(wtot_q))
    else $error("bit total changed during a read");
`endif

endmodule
